[sv/range_add_range_sum_tree_macros.svh]
// Assertion helpers for the range-add / range-sum tree.
`ifndef RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RARS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RARS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rars_pkg.sv]
package rars_pkg;

	typedef enum logic [1:0] {
		CMD_READ = 2'd0,
		CMD_SUM  = 2'd1,
		CMD_ADD  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_MUL,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_QRY_RD,
		ST_QRY_ACC,
		ST_QRY_MUL,
		ST_QRY_FIN,
		ST_OUT
	} state_t;

	localparam int unsigned FIELD_W = 10;
	localparam int unsigned DATA_W  = 64;

endpackage

[sv/range_add_range_sum_tree.sv]
// Range add / range sum over LEAVES signed 64-bit values, kept as two binary indexed trees.
// Range add: two index walks, each step a read-modify-write of the tree
// memories. Range sum or point read: two prefix walks plus a shared multiply.
// One item at a time; in_stall is high until the item finishes.
// After reset the memories are swept to zero with the input stalled.
`include "range_add_range_sum_tree_macros.svh"

module range_add_range_sum_tree #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [9:0]  range_first,
	input  logic [9:0]  range_last,
	input  logic signed [63:0] add_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [63:0] range_total,
	output logic        empty_range
);
	import rars_pkg::*;

	localparam int unsigned AW = $clog2(LEAVES + 1);
	localparam int unsigned PW = $clog2(LEAVES + 2) + 1;
	localparam int unsigned CW = (PW > FIELD_W) ? PW : FIELD_W;

	state_t state_q, state_d;

	logic [DATA_W-1:0] tree1_mem [0:LEAVES];
	logic [DATA_W-1:0] tree2_mem [0:LEAVES];
	logic [DATA_W-1:0] rd1_q, rd2_q;

	logic [AW-1:0]     clr_q;
	logic              second_q;
	logic              out_valid_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     l_q, r_q;
	logic [DATA_W-1:0] amt_q, prod_q, s1_q, s2_q, acc_q, out_sum_q;
	logic              empty_q, out_empty_q;

	logic              accept, out_free, pos_over;
	logic              mem_we, mem_re;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data1, wr_data2, delta1, delta2;
	logic [PW-1:0]     lowbit;
	logic [CW-1:0]     first_c, last_c;
	logic              in_empty;
	logic [PW-1:0]     mul_b;
	logic [DATA_W-1:0] mul_a, mul_p, prefix;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign pos_over = pos_q > PW'(LEAVES);
	assign lowbit   = pos_q & (~pos_q + PW'(1));

	// Point read takes last = first; clip last to the top leaf.
	always_comb begin
		first_c = CW'(range_first);
		last_c  = (command == CMD_READ) ? CW'(range_first) : CW'(range_last);
		if (last_c > CW'(LEAVES - 1))
			last_c = CW'(LEAVES - 1);
		in_empty = first_c > last_c;
	end

	// Shared multiplier: amount times index for adds, prefix weight for queries.
	always_comb begin
		if (state_q == ST_ADD_MUL) begin
			mul_a = amt_q;
			mul_b = second_q ? (r_q + PW'(1)) : l_q;
		end else begin
			mul_a = s1_q;
			mul_b = second_q ? l_q : (r_q + PW'(1));
		end
		mul_p = mul_a * {{(DATA_W-PW){1'b0}}, mul_b};
	end

	assign delta1   = second_q ? (~amt_q + 64'd1) : amt_q;
	assign delta2   = second_q ? (~prod_q + 64'd1) : prod_q;
	assign prefix   = prod_q - s2_q;
	assign wr_addr  = (state_q == ST_CLEAR) ? clr_q : pos_q[AW-1:0];
	assign wr_data1 = (state_q == ST_CLEAR) ? '0 : rd1_q + delta1;
	assign wr_data2 = (state_q == ST_CLEAR) ? '0 : rd2_q + delta2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == AW'(LEAVES)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_ADD && !in_empty)
						state_d = ST_ADD_MUL;
					else if (command == CMD_READ || command == CMD_SUM)
						state_d = in_empty ? ST_OUT : ST_QRY_RD;
				end
			end
			ST_ADD_MUL: state_d = ST_WALK_RD;
			ST_WALK_RD: begin
				if (pos_over)
					state_d = second_q ? ST_IDLE : ST_ADD_MUL;
				else
					state_d = ST_WALK_WR;
			end
			ST_WALK_WR: state_d = ST_WALK_RD;
			ST_QRY_RD:  state_d = (pos_q == '0) ? ST_QRY_MUL : ST_QRY_ACC;
			ST_QRY_ACC: state_d = ST_QRY_RD;
			ST_QRY_MUL: state_d = ST_QRY_FIN;
			ST_QRY_FIN: state_d = second_q ? ST_OUT : ST_QRY_RD;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		unique case (state_q)
			ST_CLEAR:   mem_we = 1'b1;
			ST_IDLE:    in_stall = 1'b0;
			ST_WALK_RD: mem_re = !pos_over;
			ST_WALK_WR: mem_we = 1'b1;
			ST_QRY_RD:  mem_re = (pos_q != '0);
			default:    mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (accept)
				second_q <= 1'b0;
			else if (state_q == ST_WALK_RD && pos_over)
				second_q <= 1'b1;
			else if (state_q == ST_QRY_FIN)
				second_q <= 1'b1;
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_q     <= first_c[PW-1:0];
			r_q     <= last_c[PW-1:0];
			amt_q   <= add_amount;
			empty_q <= in_empty;
			acc_q   <= '0;
			s1_q    <= '0;
			s2_q    <= '0;
			pos_q   <= last_c[PW-1:0] + PW'(1);
		end
		unique case (state_q)
			ST_ADD_MUL: begin
				prod_q <= mul_p;
				pos_q  <= second_q ? (r_q + PW'(2)) : (l_q + PW'(1));
			end
			ST_WALK_WR: pos_q <= pos_q + lowbit;
			ST_QRY_ACC: begin
				s1_q  <= s1_q + rd1_q;
				s2_q  <= s2_q + rd2_q;
				pos_q <= pos_q - lowbit;
			end
			ST_QRY_MUL: prod_q <= mul_p;
			ST_QRY_FIN: begin
				acc_q <= second_q ? (acc_q - prefix) : (acc_q + prefix);
				s1_q  <= '0;
				s2_q  <= '0;
				pos_q <= l_q;
			end
			ST_OUT: begin
				if (out_free) begin
					out_sum_q   <= empty_q ? '0 : acc_q;
					out_empty_q <= empty_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree1_mem[wr_addr] <= wr_data1;
			tree2_mem[wr_addr] <= wr_data2;
		end
		if (mem_re) begin
			rd1_q <= tree1_mem[pos_q[AW-1:0]];
			rd2_q <= tree2_mem[pos_q[AW-1:0]];
		end
	end

	assign out_valid   = out_valid_q;
	assign range_total = out_sum_q;
	assign empty_range = out_empty_q;

	`RARS_ASSERT_IMP(a_clear_stalls, state_q == ST_CLEAR, in_stall,
		"input taken during memory sweep")
	`RARS_ASSERT_IMP(a_empty_zero, out_valid && empty_range, range_total == '0,
		"empty range with nonzero sum")
	`RARS_ASSERT_IMP(a_walk_in_range, state_q == ST_WALK_WR,
		pos_q != '0 && pos_q <= PW'(LEAVES), "tree write outside memory")
	`RARS_ASSERT_NXT(a_add_starts, accept && command == CMD_ADD && !in_empty,
		state_q == ST_ADD_MUL, "range add transfer did not start a walk")
	`RARS_ASSERT_NXT(a_out_load, state_q == ST_OUT && out_free, out_valid,
		"finished result not presented")

endmodule
